### hw/rtl/edc_pkg.sv
// Shared widths, types and helpers of the elastic disc collision pipeline.
// Used by every module under hw/rtl; depends on nothing.
package edc_pkg;

  localparam int unsigned NumW     = 116;  // 2*m*|w.d|*|d_k|, Q68.48 magnitude
  localparam int unsigned DenW     = 83;   // (m1+m2)*|d|^2, Q51.32
  localparam int unsigned QW       = 35;   // quotient bits kept below the clamp
  localparam int unsigned RemW     = DenW + QW;
  localparam int unsigned FrontLat = 6;
  localparam int unsigned DivLat   = QW + 1;
  localparam int unsigned Lat      = FrontLat + DivLat + 1;
  localparam int unsigned InW      = 352;
  localparam int unsigned OutW     = 128;

  // correction lanes
  localparam int unsigned LaneAx = 0;
  localparam int unsigned LaneAy = 1;
  localparam int unsigned LaneBx = 2;
  localparam int unsigned LaneBy = 3;

  typedef struct packed {
    logic signed [31:0] by;
    logic signed [31:0] bx;
    logic signed [31:0] ay;
    logic signed [31:0] ax;
  } vel_t;

  typedef struct packed {
    vel_t       vel;
    logic [3:0] neg;
    logic       contact;
    logic       coinc;
  } meta_t;

  function automatic logic [31:0] sat32(input logic signed [37:0] v);
    logic [31:0] r;
    if (v > 38'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -38'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### hw/rtl/edc_front.sv
// Geometry front end: differences, products, overlap test and the wide
// numerators and denominator, six register stages. Depends on edc_pkg.
module edc_front (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic [edc_pkg::InW-1:0]               data_i,
  output logic [3:0][edc_pkg::NumW-1:0]         num_o,
  output logic [edc_pkg::DenW-1:0]              den_o,
  output edc_pkg::meta_t                        meta_o
);

  logic signed [31:0] apx, apy, bpx, bpy;
  logic [15:0]        am, bm;
  logic [30:0]        ar, br;
  edc_pkg::vel_t      vin;

  assign apx    = data_i[31:0];
  assign apy    = data_i[63:32];
  assign vin.ax = data_i[95:64];
  assign vin.ay = data_i[127:96];
  assign am     = data_i[143:128];
  assign ar     = data_i[174:144];
  assign bpx    = data_i[206:175];
  assign bpy    = data_i[238:207];
  assign vin.bx = data_i[270:239];
  assign vin.by = data_i[302:271];
  assign bm     = data_i[318:303];
  assign br     = data_i[349:319];

  edc_pkg::vel_t vel_q [edc_pkg::FrontLat];

  // stage 1
  logic signed [32:0] dx1_q, dy1_q, wx1_q, wy1_q;
  logic [31:0]        rs1_q;
  logic [16:0]        ms1_q, ma1_q, mb1_q;
  // stage 2
  logic [64:0]        dxx2_q, dyy2_q;
  logic signed [65:0] pwx2_q, pwy2_q;
  logic [63:0]        rr2_q, rr3_q;
  logic [32:0]        adx2_q, ady2_q;
  logic               sdx2_q, sdy2_q, sdx3_q, sdy3_q;
  logic [16:0]        ms2_q, ma2_q, mb2_q, ms3_q, ms4_q;
  // stage 3
  logic [65:0]        dist3_q, dist4_q;
  logic signed [66:0] dot3_q;
  logic [3:0][49:0]   k3_q, k4_q;
  // stage 4
  logic [65:0]        dm4_q;
  logic [3:0]         neg4_q, neg5_q, neg6_q;
  logic               ct4_q, co4_q, ct5_q, co5_q, ct6_q, co6_q;
  // stage 5
  logic [1:0][49:0]        dp5_q;
  logic [3:0][3:0][57:0]   np5_q;
  // stage 6
  logic [3:0][edc_pkg::NumW-1:0] num6_q;
  logic [edc_pkg::DenW-1:0]      den6_q;

  logic signed [65:0] dxx2_d, dyy2_d, pwx2_d, pwy2_d;
  logic [32:0]        adx2_d, ady2_d;
  logic [65:0]        dist3_d;
  logic signed [66:0] dot4_n;
  logic [66:0]        dm4_d;
  logic               dneg;

  assign dxx2_d = 66'(dx1_q) * 66'(dx1_q);
  assign dyy2_d = 66'(dy1_q) * 66'(dy1_q);
  assign pwx2_d = 66'(wx1_q) * 66'(dx1_q);
  assign pwy2_d = 66'(wy1_q) * 66'(dy1_q);
  assign adx2_d = dx1_q[32] ? 33'(-dx1_q) : 33'(dx1_q);
  assign ady2_d = dy1_q[32] ? 33'(-dy1_q) : 33'(dy1_q);
  assign dist3_d = 66'(dxx2_q) + 66'(dyy2_q);
  assign dot4_n = -dot3_q;
  assign dm4_d  = dot3_q[66] ? dot4_n : dot3_q;
  assign dneg   = dot3_q[66];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vel_q[0] <= vin;
      for (int i = 1; i < edc_pkg::FrontLat; i++) vel_q[i] <= vel_q[i-1];

      dx1_q <= 33'(bpx) - 33'(apx);
      dy1_q <= 33'(bpy) - 33'(apy);
      wx1_q <= 33'(vin.ax) - 33'(vin.bx);
      wy1_q <= 33'(vin.ay) - 33'(vin.by);
      rs1_q <= 32'(ar) + 32'(br);
      ms1_q <= 17'(am) + 17'(bm);
      ma1_q <= {am, 1'b0};
      mb1_q <= {bm, 1'b0};

      dxx2_q <= dxx2_d[64:0];
      dyy2_q <= dyy2_d[64:0];
      pwx2_q <= pwx2_d;
      pwy2_q <= pwy2_d;
      rr2_q  <= 64'(rs1_q) * 64'(rs1_q);
      adx2_q <= adx2_d;
      ady2_q <= ady2_d;
      sdx2_q <= dx1_q[32];
      sdy2_q <= dy1_q[32];
      ms2_q  <= ms1_q;
      ma2_q  <= ma1_q;
      mb2_q  <= mb1_q;

      dist3_q <= dist3_d;
      dot3_q  <= 67'(pwx2_q) + 67'(pwy2_q);
      rr3_q   <= rr2_q;
      k3_q[edc_pkg::LaneAx] <= 50'(mb2_q) * 50'(adx2_q);
      k3_q[edc_pkg::LaneAy] <= 50'(mb2_q) * 50'(ady2_q);
      k3_q[edc_pkg::LaneBx] <= 50'(ma2_q) * 50'(adx2_q);
      k3_q[edc_pkg::LaneBy] <= 50'(ma2_q) * 50'(ady2_q);
      sdx3_q <= sdx2_q;
      sdy3_q <= sdy2_q;
      ms3_q  <= ms2_q;

      // no contact for coincident centres or zero total mass
      co4_q   <= (dist3_q == '0);
      ct4_q   <= (dist3_q < 66'(rr3_q)) && (dist3_q != '0) && (ms3_q != '0);
      dist4_q <= dist3_q;
      dm4_q   <= dm4_d[65:0];
      neg4_q  <= {dneg ^ sdy3_q, dneg ^ sdx3_q, dneg ^ sdy3_q, dneg ^ sdx3_q};
      k4_q    <= k3_q;
      ms4_q   <= ms3_q;

      dp5_q[0] <= 50'(dist4_q[32:0]) * 50'(ms4_q);
      dp5_q[1] <= 50'(dist4_q[65:33]) * 50'(ms4_q);
      for (int l = 0; l < 4; l++) begin
        np5_q[l][0] <= 58'(dm4_q[32:0])  * 58'(k4_q[l][24:0]);
        np5_q[l][1] <= 58'(dm4_q[32:0])  * 58'(k4_q[l][49:25]);
        np5_q[l][2] <= 58'(dm4_q[65:33]) * 58'(k4_q[l][24:0]);
        np5_q[l][3] <= 58'(dm4_q[65:33]) * 58'(k4_q[l][49:25]);
      end
      neg5_q <= neg4_q;
      ct5_q  <= ct4_q;
      co5_q  <= co4_q;

      den6_q <= edc_pkg::DenW'(dp5_q[0]) + (edc_pkg::DenW'(dp5_q[1]) << 33);
      for (int l = 0; l < 4; l++) begin
        num6_q[l] <= edc_pkg::NumW'(np5_q[l][0])
                   + (edc_pkg::NumW'(np5_q[l][1]) << 25)
                   + (edc_pkg::NumW'(np5_q[l][2]) << 33)
                   + (edc_pkg::NumW'(np5_q[l][3]) << 58);
      end
      neg6_q <= neg5_q;
      ct6_q  <= ct5_q;
      co6_q  <= co5_q;
    end
  end

  assign num_o          = num6_q;
  assign den_o          = den6_q;
  assign meta_o.vel     = vel_q[edc_pkg::FrontLat-1];
  assign meta_o.neg     = neg6_q;
  assign meta_o.contact = ct6_q;
  assign meta_o.coinc   = co6_q;

endmodule

### hw/rtl/edc_div.sv
// Pipelined restoring divider, one quotient bit per stage, quotient clamped
// to 2^QW. Depends on edc_pkg.
module edc_div (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [edc_pkg::NumW-1:0]   num_i,
  input  logic [edc_pkg::DenW-1:0]   den_i,
  output logic [edc_pkg::QW:0]       q_o
);

  localparam int unsigned W = edc_pkg::RemW;
  localparam int unsigned N = edc_pkg::QW;

  logic [W-1:0]               rem_q [N+1];
  logic [N:0]                 q_q   [N+1];
  logic [edc_pkg::DenW-1:0]   den_q [N+1];

  logic ovf;
  assign ovf = W'(num_i) >= (W'(den_i) << N);

  // clamp at entry: any quotient this large saturates the velocity anyway
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= ovf ? '0 : W'(num_i);
      q_q[0]   <= ovf ? (N+1)'(1) << N : '0;
      den_q[0] <= den_i;
    end
  end

  for (genvar k = 1; k <= N; k++) begin : g_stage
    logic [W-1:0] sh;
    logic         ge;
    assign sh = W'(den_q[k-1]) << (N - k);
    assign ge = rem_q[k-1] >= sh;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? rem_q[k-1] - sh : rem_q[k-1];
        q_q[k]   <= q_q[k-1] | ((N+1)'(ge) << (N - k));
        den_q[k] <= den_q[k-1];
      end
    end
  end

  assign q_o = q_q[N];

endmodule

### hw/rtl/elastic_disc_collision_2d.sv
// Elastic disc collision, 2D. Top level: stream ports, pipeline control,
// divider lanes and output stage. Depends on edc_pkg, edc_front, edc_div.
//
// Usage: present one disc pair per word on s_axis; each word yields exactly
// one word on m_axis carrying the four new velocities (tdata) and the
// contact and coincident flags (tuser). Words leave in the order they came.
// A word passes from acceptance to m_axis_tvalid through six front-end
// stages (differences, products, overlap test, wide numerators), one divider
// entry stage plus 35 stages of one quotient bit each, and one output stage
// that applies the sign, adds and saturates. Throughput is one word per cycle
// unless the output stalls; the 35-stage divider pipeline sets the latency.
// The pipeline moves as a whole: when m_axis_tvalid is high and the
// receiver holds m_axis_tready low, every stage holds and s_axis_tready
// falls; while the output stage holds a bubble the pipe keeps taking words.
// Reset clears all valid bits; nothing else is needed since the block keeps
// no state between pairs.
module elastic_disc_collision_2d (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // a_pos_x, a_pos_y, a_vel_x, a_vel_y, a_mass, a_radius,
  // b_pos_x, b_pos_y, b_vel_x, b_vel_y, b_mass, b_radius, 2 zero bits
  input  logic [edc_pkg::InW-1:0]   s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // a_new_vel_x, a_new_vel_y, b_new_vel_x, b_new_vel_y
  output logic [edc_pkg::OutW-1:0]  m_axis_tdata,
  // contact, coincident
  output logic [1:0]                m_axis_tuser
);

  logic [edc_pkg::Lat-1:0] v_q;
  logic en;

  assign en            = !v_q[edc_pkg::Lat-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = v_q[edc_pkg::Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[edc_pkg::Lat-2:0], s_axis_tvalid};
    end
  end

  logic [3:0][edc_pkg::NumW-1:0] num;
  logic [edc_pkg::DenW-1:0]      den;
  edc_pkg::meta_t                meta;
  logic [3:0][edc_pkg::QW:0]     q;

  edc_front u_front (
    .clk_i  (clk_i),
    .en_i   (en),
    .data_i (s_axis_tdata),
    .num_o  (num),
    .den_o  (den),
    .meta_o (meta)
  );

  for (genvar l = 0; l < 4; l++) begin : g_lane
    edc_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num[l]),
      .den_i (den),
      .q_o   (q[l])
    );
  end

  edc_pkg::meta_t meta_q [edc_pkg::DivLat];

  always_ff @(posedge clk_i) begin
    if (en) begin
      meta_q[0] <= meta;
      for (int i = 1; i < edc_pkg::DivLat; i++) meta_q[i] <= meta_q[i-1];
    end
  end

  edc_pkg::meta_t     mt;
  logic signed [37:0] corr [4];
  logic signed [37:0] sum  [4];
  logic signed [31:0] vin  [4];
  logic [edc_pkg::OutW-1:0] out_d, out_q;
  logic [1:0]               user_q;

  assign mt = meta_q[edc_pkg::DivLat-1];
  assign vin[edc_pkg::LaneAx] = mt.vel.ax;
  assign vin[edc_pkg::LaneAy] = mt.vel.ay;
  assign vin[edc_pkg::LaneBx] = mt.vel.bx;
  assign vin[edc_pkg::LaneBy] = mt.vel.by;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      corr[l] = mt.neg[l] ? -$signed(38'(q[l])) : $signed(38'(q[l]));
      // first disc loses the correction, second gains it
      if (l < 2) begin
        sum[l] = 38'(vin[l]) - corr[l];
      end else begin
        sum[l] = 38'(vin[l]) + corr[l];
      end
      out_d[l*32 +: 32] = mt.contact ? edc_pkg::sat32(sum[l]) : vin[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q  <= out_d;
      user_q <= {mt.coinc, mt.contact};
    end
  end

  assign m_axis_tdata = out_q;
  assign m_axis_tuser = user_q;

  a_flags_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("contact and coincident both set");

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v_q))
    else $error("pipeline valid bits moved during stall");

  a_pass_through : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && !mt.contact) |=> (m_axis_tdata == $past(mt.vel)))
    else $error("velocities changed without contact");

endmodule

### verif/elastic_disc_collision_2d_tb.sv
// Testbench for elastic_disc_collision_2d: drives disc pairs on the input stream
// and checks every output word against a predictor that models the collision
// at full width. Depends on edc_pkg and the RTL of the block.
`timescale 1ns / 100ps

module elastic_disc_collision_2d_tb;

  typedef struct {
    logic signed [31:0] a_pos_x, a_pos_y, a_vel_x, a_vel_y;
    logic [15:0]        a_mass;
    logic [30:0]        a_radius;
    logic signed [31:0] b_pos_x, b_pos_y, b_vel_x, b_vel_y;
    logic [15:0]        b_mass;
    logic [30:0]        b_radius;
  } disc_pair_t;

  typedef struct {
    logic [31:0] a_vx, a_vy, b_vx, b_vy;
    logic        contact;
    logic        coinc;
  } new_vel_t;

  localparam int unsigned CycleLimit = 400000;

  class disc_velocity_board;
    new_vel_t expected_vels[$];
    int       n_mismatch;

    function new();
      n_mismatch = 0;
    endfunction

    static function logic [31:0] saturate(logic signed [63:0] v);
      logic [31:0] r;
      if (v > 64'sd2147483647) r = 32'h7fff_ffff;
      else if (v < -64'sd2147483648) r = 32'h8000_0000;
      else r = v[31:0];
      return r;
    endfunction

    // 2*m*(w.d)*d_k / den, truncated toward zero, clamped to 2^40 (the divider clamps to 2^35)
    static function logic signed [63:0] impulse(logic [16:0] m, logic signed [127:0] dot,
                                                logic signed [63:0] comp,
                                                logic [127:0] den);
      logic [127:0] magdot, magc, num, q;
      logic signed [63:0] r;
      magdot = dot < 0 ? -dot : dot;
      magc = 128'(comp < 0 ? -comp : comp);
      num = magdot * magc * (128'(m) << 1);
      q = num / den;
      if (q > (128'd1 << 40)) q = 128'd1 << 40;
      r = q[63:0];
      return ((dot < 0) != (comp < 0)) ? -r : r;
    endfunction

    function void note_pair(disc_pair_t p);
      logic signed [63:0]  dx, dy, wx, wy, mx, my, nax, nay, nbx, nby;
      logic signed [127:0] dot;
      logic [127:0]        dist2, rsq, den;
      logic [32:0]         rs;
      logic [16:0]         msum;
      new_vel_t            e;
      dx = 64'(p.b_pos_x) - 64'(p.a_pos_x);
      dy = 64'(p.b_pos_y) - 64'(p.a_pos_y);
      wx = 64'(p.a_vel_x) - 64'(p.b_vel_x);
      wy = 64'(p.a_vel_y) - 64'(p.b_vel_y);
      mx = dx < 0 ? -dx : dx;
      my = dy < 0 ? -dy : dy;
      dist2 = 128'(mx) * 128'(mx) + 128'(my) * 128'(my);
      rs = 33'(p.a_radius) + 33'(p.b_radius);
      rsq = 128'(rs) * 128'(rs);
      msum = 17'(p.a_mass) + 17'(p.b_mass);
      e.coinc = (dist2 == '0);
      e.contact = (dist2 < rsq) && !e.coinc && (msum != '0);
      nax = 64'(p.a_vel_x); nay = 64'(p.a_vel_y);
      nbx = 64'(p.b_vel_x); nby = 64'(p.b_vel_y);
      if (e.contact) begin
        dot = 128'(wx) * 128'(dx) + 128'(wy) * 128'(dy);
        den = dist2 * 128'(msum);
        nax = nax - impulse(17'(p.b_mass), dot, dx, den);
        nay = nay - impulse(17'(p.b_mass), dot, dy, den);
        nbx = nbx + impulse(17'(p.a_mass), dot, dx, den);
        nby = nby + impulse(17'(p.a_mass), dot, dy, den);
      end
      e.a_vx = saturate(nax);
      e.a_vy = saturate(nay);
      e.b_vx = saturate(nbx);
      e.b_vy = saturate(nby);
      expected_vels = {expected_vels, e};
    endfunction

    function void check_velocities(logic [127:0] data, logic [1:0] user);
      new_vel_t e;
      if (expected_vels.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected word: data=%h user=%b", data, user);
        return;
      end
      e = expected_vels.pop_front();
      if (data[31:0] !== e.a_vx || data[63:32] !== e.a_vy || data[95:64] !== e.b_vx ||
          data[127:96] !== e.b_vy || user[0] !== e.contact || user[1] !== e.coinc) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display({"mismatch: exp a=(%h,%h) b=(%h,%h) contact=%b coinc=%b,",
                    " got a=(%h,%h) b=(%h,%h) contact=%b coinc=%b"},
                   e.a_vx, e.a_vy, e.b_vx, e.b_vy, e.contact, e.coinc,
                   data[31:0], data[63:32], data[95:64], data[127:96], user[0], user[1]);
      end
    endfunction

    function int pending();
      return expected_vels.size();
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [edc_pkg::InW-1:0] s_axis_tdata = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [edc_pkg::OutW-1:0] m_axis_tdata;
  logic [1:0]              m_axis_tuser;

  disc_velocity_board board = new();
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned n_cycles = 0;

  elastic_disc_collision_2d u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    if (m_axis_tvalid && m_axis_tready) board.check_velocities(m_axis_tdata, m_axis_tuser);
    n_cycles++;
    if (n_cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [edc_pkg::InW-1:0] pack_pair(disc_pair_t p);
    return {2'b00, p.b_radius, p.b_mass, p.b_vel_y, p.b_vel_x, p.b_pos_y, p.b_pos_x,
            p.a_radius, p.a_mass, p.a_vel_y, p.a_vel_x, p.a_pos_y, p.a_pos_x};
  endfunction

  // Hold the word until the block takes it; valid stays high for the next word.
  task automatic send_pair(disc_pair_t p);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pack_pair(p);
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_pair(p);
  endtask

  task automatic drain();
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  function automatic disc_pair_t noise_pair();
    disc_pair_t p;
    p.a_pos_x = $urandom; p.a_pos_y = $urandom; p.a_vel_x = $urandom; p.a_vel_y = $urandom;
    p.b_pos_x = $urandom; p.b_pos_y = $urandom; p.b_vel_x = $urandom; p.b_vel_y = $urandom;
    p.a_mass = 16'($urandom_range(65535, 1)); p.b_mass = 16'($urandom_range(65535, 1));
    p.a_radius = 31'($urandom); p.b_radius = 31'($urandom);
    return p;
  endfunction

  // Nearby discs at a random scale, so most of these overlap.
  function automatic disc_pair_t close_pair();
    disc_pair_t p;
    int unsigned sh, vsh;
    sh = $urandom_range(28, 4);
    vsh = $urandom_range(31, 4);
    p = noise_pair();
    p.b_pos_x = p.a_pos_x + ($signed($urandom) >>> (32 - sh));
    p.b_pos_y = p.a_pos_y + ($signed($urandom) >>> (32 - sh));
    p.a_vel_x = $signed($urandom) >>> (32 - vsh);
    p.a_vel_y = $signed($urandom) >>> (32 - vsh);
    p.b_vel_x = $signed($urandom) >>> (32 - vsh);
    p.b_vel_y = $signed($urandom) >>> (32 - vsh);
    p.a_radius = 31'($urandom_range(1 << sh, 0));
    p.b_radius = 31'($urandom_range(1 << sh, 0));
    if ($urandom_range(1)) begin
      p.a_mass = 16'($urandom_range(8, 1));
      p.b_mass = 16'($urandom_range(8, 1));
    end
    return p;
  endfunction

  function automatic disc_pair_t pair_of(int ax, int ay, int avx, int avy, int am, int ar,
                                          int bx, int by, int bvx, int bvy, int bm, int br);
    disc_pair_t p;
    p.a_pos_x = ax; p.a_pos_y = ay; p.a_vel_x = avx; p.a_vel_y = avy;
    p.a_mass = 16'(am); p.a_radius = 31'(ar);
    p.b_pos_x = bx; p.b_pos_y = by; p.b_vel_x = bvx; p.b_vel_y = bvy;
    p.b_mass = 16'(bm); p.b_radius = 31'(br);
    return p;
  endfunction

  initial begin
    localparam int One = 32'h0001_0000;
    localparam int Max = 32'h7fff_ffff;
    localparam int Min = 32'h8000_0000;
    disc_pair_t p;
    int unsigned phase;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 30;
    rx_idle_pct = 73;
    // head-on, equal masses
    send_pair(pair_of(0, 0, One, 0, 1, One, One, 0, -One, 0, 1, One));
    // oblique, unequal masses
    send_pair(pair_of(0, 0, 3 * One, One, 1, One, One, One / 2, 0, -One, 65535, One));
    // coincident centres, large and zero radii
    send_pair(pair_of(5, 7, One, 2, 3, Max, 5, 7, -3, 4, 9, Max));
    send_pair(pair_of(Min, Max, Max, Min, 1, 0, Min, Max, Min, Max, 1, 0));
    // zero radii, near centres: never contact
    send_pair(pair_of(0, 0, One, One, 2, 0, 1, 0, -One, 0, 3, 0));
    // exactly touching: not an overlap
    send_pair(pair_of(0, 0, One, 0, 1, One, 2 * One, 0, -One, 0, 1, One));
    // far apart
    send_pair(pair_of(Min, Min, 1, 1, 7, One, Max, Max, 2, 2, 7, One));
    // saturating corrections
    send_pair(pair_of(0, 0, Max, Max, 1, Max, 1, 1, Min, Min, 65535, Max));
    send_pair(pair_of(0, 0, Min, Min, 65535, Max, 1, 1, Max, Max, 1, Max));
    send_pair(pair_of(Min, Min, Max, Min, 65535, Max, Max, Max, Min, Max, 65535, Max));
    send_pair(pair_of(Max, Max, Min, Max, 1, Max, Min, Min, Max, Min, 1, Max));
    // tiny offset, huge velocities
    send_pair(pair_of(0, 0, Max, 0, 65535, 2, 1, 0, Min, 0, 65535, 2));
    send_pair(pair_of(-1, -1, 0, 0, 1, 1, 0, 0, Max, Max, 65535, 1));
    // separating discs still overlapping
    send_pair(pair_of(0, 0, -One, 0, 4, One, One, 0, One, 0, 5, One));
    s_axis_tvalid <= 1'b0;
    drain();

    for (phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 73 : 0;
      rx_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 30 : 0;
      repeat (460) begin
        p = ($urandom_range(99) < 75) ? close_pair() : noise_pair();
        send_pair(p);
        if ($urandom_range(299) == 0) begin
          s_axis_tvalid <= 1'b0;
          drain();
        end
      end
    end
    s_axis_tvalid <= 1'b0;
    drain();
    repeat (edc_pkg::Lat + 10) @(posedge clk_i);
    if (board.n_mismatch == 0 && board.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
